// ===== rtl/tree_lca_binary_lifting_macros.svh =====
// Assertion macros for the lowest common ancestor block.
// Each macro expects clk and rst in scope.
`ifndef TREE_LCA_BINARY_LIFTING_MACROS_SVH
`define TREE_LCA_BINARY_LIFTING_MACROS_SVH
`ifndef SYNTHESIS
`define TLB_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("tlb: same-cycle check failed");
`define TLB_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tlb: next-cycle check failed");
`else
`define TLB_ASSERT_SAME(label, pre, post)
`define TLB_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== rtl/tlb_pkg.sv =====
`default_nettype none
package tlb_pkg;

  localparam int NODE_W     = 16;
  localparam int DEPTH_W    = 16;
  localparam int PATH_W     = 17;
  localparam int RED_STEPS  = 4;
  localparam int RED_CYCLES = NODE_W / RED_STEPS;
  localparam int RED_CNT_W  = $clog2(RED_CYCLES);

  typedef struct packed {
    logic              operation;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } in_t;

  typedef struct packed {
    logic [NODE_W-1:0]  ancestor;
    logic [DEPTH_W-1:0] ancestor_depth;
    logic [PATH_W-1:0]  path_length;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED,
    ST_LD_PAR,
    ST_ROOT,
    ST_LD_DEP,
    ST_LD_LVL,
    ST_Q_DA,
    ST_Q_DB,
    ST_Q_SW,
    ST_Q_LIFT,
    ST_Q_CMP,
    ST_Q_JB,
    ST_Q_JC,
    ST_Q_UPD,
    ST_Q_ANC
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAP,
    CMD_RED,
    CMD_LD_PAR,
    CMD_ROOT,
    CMD_LD_DEP,
    CMD_LD_LVL,
    CMD_Q_DA,
    CMD_Q_DB,
    CMD_Q_SW,
    CMD_LIFT,
    CMD_CMP,
    CMD_JB,
    CMD_JC,
    CMD_UPD,
    CMD_ANC
  } dp_cmd_t;

  typedef enum logic [2:0] {
    LVL_HOLD,
    LVL_CLR,
    LVL_INC,
    LVL_DEC,
    LVL_TOP
  } lvl_op_t;

  typedef struct packed {
    dp_cmd_t cmd;
    lvl_op_t lvl_op;
  } ctl_t;

  typedef struct packed {
    logic red_last;
    logic is_query;
    logic root;
    logic lvl_last;
    logic lvl_zero;
    logic a_eq_b;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/tlb_ram.sv =====
`default_nettype none
module tlb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/tlb_ctrl.sv =====
`default_nettype none
module tlb_ctrl import tlb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output      logic busy,
  input  wire sts_t sts,
  output      ctl_t ctl
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_RED;
      ST_RED: begin
        if (sts.red_last) state_next = sts.is_query ? ST_Q_DA : ST_LD_PAR;
      end
      ST_LD_PAR: state_next = sts.root ? ST_ROOT : ST_LD_DEP;
      ST_ROOT:   if (sts.lvl_last) state_next = ST_IDLE;
      ST_LD_DEP: state_next = ST_LD_LVL;
      ST_LD_LVL: if (sts.lvl_last) state_next = ST_IDLE;
      ST_Q_DA:   state_next = ST_Q_DB;
      ST_Q_DB:   state_next = ST_Q_SW;
      ST_Q_SW:   state_next = ST_Q_LIFT;
      ST_Q_LIFT: if (sts.lvl_last) state_next = ST_Q_CMP;
      ST_Q_CMP:  state_next = sts.a_eq_b ? ST_Q_ANC : ST_Q_JB;
      ST_Q_JB:   state_next = ST_Q_JC;
      ST_Q_JC:   state_next = sts.lvl_zero ? ST_Q_UPD : ST_Q_JB;
      ST_Q_UPD:  state_next = ST_Q_ANC;
      ST_Q_ANC:  state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.cmd    = CMD_NONE;
    ctl.lvl_op = LVL_HOLD;
    busy       = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:   if (start) ctl.cmd = CMD_CAP;
      ST_RED:    ctl.cmd = CMD_RED;
      ST_LD_PAR: begin
        ctl.cmd    = CMD_LD_PAR;
        ctl.lvl_op = LVL_CLR;
      end
      ST_ROOT: begin
        ctl.cmd    = CMD_ROOT;
        ctl.lvl_op = LVL_INC;
      end
      ST_LD_DEP: begin
        ctl.cmd    = CMD_LD_DEP;
        ctl.lvl_op = LVL_INC;
      end
      ST_LD_LVL: begin
        ctl.cmd    = CMD_LD_LVL;
        ctl.lvl_op = LVL_INC;
      end
      ST_Q_DA:   ctl.cmd = CMD_Q_DA;
      ST_Q_DB:   ctl.cmd = CMD_Q_DB;
      ST_Q_SW: begin
        ctl.cmd    = CMD_Q_SW;
        ctl.lvl_op = LVL_CLR;
      end
      ST_Q_LIFT: begin
        ctl.cmd    = CMD_LIFT;
        ctl.lvl_op = LVL_INC;
      end
      ST_Q_CMP: begin
        ctl.cmd    = CMD_CMP;
        ctl.lvl_op = LVL_TOP;
      end
      ST_Q_JB:   ctl.cmd = CMD_JB;
      ST_Q_JC: begin
        ctl.cmd    = CMD_JC;
        ctl.lvl_op = LVL_DEC;
      end
      ST_Q_UPD:  ctl.cmd = CMD_UPD;
      ST_Q_ANC:  ctl.cmd = CMD_ANC;
      default:   ctl.cmd = CMD_NONE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/tlb_dpath.sv =====
`default_nettype none
module tlb_dpath import tlb_pkg::*; #(
  parameter int NODES  = 65536,
  parameter int LEVELS = 17
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire in_t  request,
  input  wire ctl_t ctl,
  output      sts_t sts,
  output      out_t result,
  output      logic done
);
  localparam int NW     = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int IW     = (NW < NODE_W) ? NW : NODE_W;
  localparam int LW     = $clog2(LEVELS);
  localparam int TAW    = NW + LW;
  localparam int TDEPTH = NODES << LW;
  localparam int MW     = NW + NODE_W;
  localparam logic [MW-1:0] MOD_TOP = MW'(NODES) << (NODE_W - 1);

  logic [NODE_W-1:0]    ra, rb, ra_r, rb_r;
  logic [MW-1:0]        m;
  logic [RED_CNT_W-1:0] red_cnt;
  logic                 is_q;
  logic [LW-1:0]        lvl, lvl_rd;
  logic [IW-1:0]        ca, cb, pa, anc;
  logic [IW-1:0]        na, nb, tnode, a_now, a_new, ld_node;
  logic                 a_pend, jump, ld_self;
  logic [DEPTH_W-1:0]   diff, da, result_db;
  logic [PATH_W-1:0]    path;

  logic               t_we;
  logic [TAW-1:0]     t_waddr, t_raddr;
  logic [IW-1:0]      t_wdata, t_rdata;
  logic               d_we;
  logic [NW-1:0]      d_waddr, d_raddr;
  logic [DEPTH_W-1:0] d_wdata, d_rdata;

  function automatic logic [TAW-1:0] taddr(input logic [IW-1:0] node,
                                           input logic [LW-1:0] level);
    return {NW'(node), level};
  endfunction

  // one restoring step of the modulo reduction
  function automatic logic [NODE_W-1:0] red_step(input logic [NODE_W-1:0] r,
                                                 input logic [MW-1:0] md);
    logic [MW-1:0] rx;
    rx = MW'(r);
    if (rx >= md) rx = rx - md;
    return rx[NODE_W-1:0];
  endfunction

  tlb_ram #(.WIDTH(IW), .DEPTH(TDEPTH)) u_anc_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  tlb_ram #(.WIDTH(DEPTH_W), .DEPTH(NODES)) u_dep_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  always_comb begin
    ra_r = ra;
    rb_r = rb;
    for (int j = 0; j < RED_STEPS; j++) begin
      ra_r = red_step(ra_r, m >> j);
      rb_r = red_step(rb_r, m >> j);
    end
  end

  assign na     = ra[IW-1:0];
  assign nb     = rb[IW-1:0];
  assign tnode  = t_rdata;
  // once the chain reaches the node being loaded, the read port hits the entry
  // written in the same cycle and returns the old word: take the node itself
  assign ld_node = ld_self ? na : tnode;
  // the lifted node sits in the read port when the last lift step read
  assign a_now  = a_pend ? tnode : ca;
  assign jump   = (pa != tnode);
  assign a_new  = jump ? pa : ca;
  assign lvl_rd = (lvl == '0) ? '0 : lvl - LW'(1);
  assign path   = PATH_W'(da) + PATH_W'(result_db) - {d_rdata, 1'b0};

  assign sts.red_last = (red_cnt == RED_CNT_W'(RED_CYCLES - 1));
  assign sts.is_query = is_q;
  assign sts.root     = (na == nb);
  assign sts.lvl_last = (lvl == LW'(LEVELS - 1));
  assign sts.lvl_zero = (lvl == '0);
  assign sts.a_eq_b   = (a_now == cb);

  always_comb begin
    t_we    = 1'b0;
    t_waddr = '0;
    t_wdata = '0;
    t_raddr = '0;
    d_we    = 1'b0;
    d_waddr = '0;
    d_wdata = '0;
    d_raddr = '0;
    unique case (ctl.cmd)
      CMD_ROOT: begin
        d_we    = 1'b1;
        d_waddr = NW'(na);
        t_we    = 1'b1;
        t_waddr = taddr(na, lvl);
        t_wdata = na;
      end
      CMD_LD_PAR: begin
        t_we    = 1'b1;
        t_waddr = taddr(na, '0);
        t_wdata = nb;
        d_raddr = NW'(nb);
      end
      CMD_LD_DEP: begin
        d_we    = 1'b1;
        d_waddr = NW'(na);
        d_wdata = d_rdata + DEPTH_W'(1);
        t_raddr = taddr(nb, '0);
      end
      CMD_LD_LVL: begin
        t_we    = 1'b1;
        t_waddr = taddr(na, lvl);
        t_wdata = ld_node;
        t_raddr = taddr(ld_node, lvl);
      end
      CMD_Q_DA: d_raddr = NW'(na);
      CMD_Q_DB: d_raddr = NW'(nb);
      CMD_LIFT: t_raddr = taddr(a_now, lvl);
      CMD_CMP: begin
        d_raddr = NW'(a_now);
        t_raddr = taddr(a_now, LW'(LEVELS - 1));
      end
      CMD_JB:  t_raddr = taddr(cb, lvl);
      CMD_JC:  t_raddr = taddr(a_new, lvl_rd);
      CMD_UPD: d_raddr = NW'(tnode);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (ctl.cmd == CMD_ANC);
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.lvl_op)
      LVL_CLR: lvl <= '0;
      LVL_INC: lvl <= lvl + LW'(1);
      LVL_DEC: lvl <= lvl - LW'(1);
      LVL_TOP: lvl <= LW'(LEVELS - 1);
      default: ;
    endcase

    unique case (ctl.cmd)
      CMD_CAP: begin
        ra      <= request.node_a;
        rb      <= request.node_b;
        is_q    <= request.operation;
        m       <= MOD_TOP;
        red_cnt <= '0;
      end
      CMD_RED: begin
        ra      <= ra_r;
        rb      <= rb_r;
        m       <= m >> RED_STEPS;
        red_cnt <= red_cnt + RED_CNT_W'(1);
      end
      CMD_LD_DEP: ld_self <= 1'b0;
      CMD_LD_LVL: ld_self <= (ld_node == na);
      CMD_Q_DB: da <= d_rdata;
      CMD_Q_SW: begin
        result_db <= d_rdata;
        a_pend    <= 1'b0;
        // lift the deeper node
        if (da < d_rdata) begin
          ca   <= nb;
          cb   <= na;
          diff <= d_rdata - da;
        end else begin
          ca   <= na;
          cb   <= nb;
          diff <= da - d_rdata;
        end
      end
      CMD_LIFT: begin
        ca     <= a_now;
        a_pend <= diff[0];
        diff   <= diff >> 1;
      end
      CMD_CMP: begin
        ca  <= a_now;
        anc <= a_now;
      end
      CMD_JB: pa <= tnode;
      CMD_JC: begin
        if (jump) begin
          ca <= pa;
          cb <= tnode;
        end
      end
      CMD_UPD: anc <= tnode;
      CMD_ANC: begin
        result.ancestor       <= NODE_W'(anc);
        result.ancestor_depth <= d_rdata;
        result.path_length    <= path;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/tree_lca_binary_lifting.sv =====
`default_nettype none
// Channel   Handshake          Word
// -------   ----------------   ----------------------------------------------
// request   start / busy       operation, node_a, node_b (accepted: start & !busy)
// result    done (one cycle)   ancestor, ancestor_depth, path_length
//
// Load: the node's depth and every level of its ancestor table are written; a
// query reads both depths, lifts the deeper node, then jumps both nodes from
// the top level down unless one is an ancestor of the other; done rises at the
// edge at which busy falls. All of this runs on the single read port of the
// ancestor table: each lift level is one dependent read, each jump level two.
// Synchronous reset clears the controller and done; both tables hold no reset.
// done is a one-cycle strobe: the receiver cannot stall it.
module tree_lca_binary_lifting import tlb_pkg::*; #(
  parameter int NODES  = 65536,
  parameter int LEVELS = 17
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output      logic busy,
  input  wire in_t  request,
  output      out_t result,
  output      logic done
);
  ctl_t ctl;
  sts_t sts;

  tlb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  tlb_dpath #(.NODES(NODES), .LEVELS(LEVELS)) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .ctl     (ctl),
    .sts     (sts),
    .result  (result),
    .done    (done)
  );

`include "tree_lca_binary_lifting_macros.svh"

  `TLB_ASSERT_SAME(a_done_idle, done, !busy)
  `TLB_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `TLB_ASSERT_NEXT(a_done_single, done, !done)
  `TLB_ASSERT_SAME(a_cap_idle, ctl.cmd == CMD_CAP, !busy && start)
endmodule
`default_nettype wire

// ===== test/lca_ops_pkg.sv =====
`timescale 1ns / 1ps
package lca_ops_pkg;

  // Operation bit of the request word.
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

endpackage

// ===== test/lca_checker.sv =====
`timescale 1ns / 1ps
module lca_checker import tlb_pkg::*; import lca_ops_pkg::*; #(
  parameter int LEVELS = 17
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  in_t  request,
  input  out_t result,
  input  logic done,
  output int   errors,
  output int   pending
);

  localparam int NODE_COUNT = 1 << NODE_W;

  // Shadow of the tree: 2^i ancestors and depth of every node.
  bit [NODE_W-1:0]  jump_tbl [NODE_COUNT][LEVELS];
  bit [DEPTH_W-1:0] depth_of [NODE_COUNT];
  out_t             answers_q[$];
  out_t             want;

  function automatic void add_node(logic [NODE_W-1:0] v, logic [NODE_W-1:0] p);
    if (v == p) begin
      depth_of[v] = '0;
      for (int i = 0; i < LEVELS; i++) jump_tbl[v][i] = v;
    end else begin
      depth_of[v]    = depth_of[p] + 1'b1;
      jump_tbl[v][0] = p;
      for (int i = 1; i < LEVELS; i++) jump_tbl[v][i] = jump_tbl[jump_tbl[v][i-1]][i-1];
    end
  endfunction

  function automatic out_t lca_of(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
    logic [NODE_W-1:0] x, y, px, py, anc;
    int                diff;
    out_t              r;
    x = a;
    y = b;
    if (depth_of[x] < depth_of[y]) begin
      x = b;
      y = a;
    end
    diff = int'(depth_of[x]) - int'(depth_of[y]);
    // lift the deeper node; bits above the table are dropped
    for (int i = 0; i < LEVELS; i++) begin
      if (((diff >> i) & 1) != 0) x = jump_tbl[x][i];
    end
    if (x == y) begin
      anc = x;
    end else begin
      for (int i = LEVELS - 1; i >= 0; i--) begin
        px = jump_tbl[x][i];
        py = jump_tbl[y][i];
        if (px != py) begin
          x = px;
          y = py;
        end
      end
      anc = jump_tbl[x][0];
    end
    r.ancestor       = anc;
    r.ancestor_depth = depth_of[anc];
    // wraps modulo 2^17 on truncation
    r.path_length    = PATH_W'(int'(depth_of[a]) + int'(depth_of[b]) - 2 * int'(depth_of[anc]));
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      // retire the result first: it belongs to an earlier query
      if (done) begin
        if (answers_q.size() == 0) begin
          $error("result word with no query waiting: ancestor %0d", result.ancestor);
          errors++;
        end else begin
          want = answers_q.pop_front();
          if (result.ancestor !== want.ancestor) begin
            $error("ancestor: expected %0d, got %0d", want.ancestor, result.ancestor);
            errors++;
          end
          if (result.ancestor_depth !== want.ancestor_depth) begin
            $error("ancestor_depth: expected %0d, got %0d",
                   want.ancestor_depth, result.ancestor_depth);
            errors++;
          end
          if (result.path_length !== want.path_length) begin
            $error("path_length: expected %0d, got %0d", want.path_length, result.path_length);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        if (request.operation == OP_QUERY) begin
          answers_q = {answers_q, lca_of(request.node_a, request.node_b)};
        end else begin
          add_node(request.node_a, request.node_b);
        end
      end
    end
    pending = answers_q.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import tlb_pkg::*;
  import lca_ops_pkg::*;

  localparam int LIFT_LEVELS = 17;
  localparam int PHASE_WORDS = 400;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic done;
  in_t  request;
  out_t result;
  int   errors;
  int   pending;
  int   idle_pct;
  int   idle_by_phase [4] = '{0, 59, 0, 6};

  // Nodes already loaded, and the tree now being grown.
  logic [NODE_W-1:0] known[$];
  logic [NODE_W-1:0] tree[$];
  logic [NODE_W-1:0] last_node;
  bit                seen [1 << NODE_W];

  always #5 clk = ~clk;

  tree_lca_binary_lifting #(
    .NODES  (1 << NODE_W),
    .LEVELS (LIFT_LEVELS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .result  (result),
    .done    (done)
  );

  lca_checker #(
    .LEVELS (LIFT_LEVELS)
  ) u_checker (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .result  (result),
    .done    (done),
    .errors  (errors),
    .pending (pending)
  );

  task automatic send_word(input op_t op, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b);
    in_t w;
    w.operation = op;
    w.node_a    = a;
    w.node_b    = b;
    // decide idle or present each cycle until the word is taken
    forever begin
      if ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk);
      end else begin
        start   <= 1'b1;
        request <= w;
        @(posedge clk);
        // busy read here is the value seen by the accepting edge
        if (!busy) break;
      end
    end
  endtask

  task automatic load(input logic [NODE_W-1:0] v, input logic [NODE_W-1:0] p);
    send_word(OP_LOAD, v, p);
    if (!seen[v]) begin
      seen[v] = 1'b1;
      known = {known, v};
    end
  endtask

  task automatic new_root(input logic [NODE_W-1:0] v);
    load(v, v);
    tree.delete();
    tree = {tree, v};
    last_node = v;
  endtask

  task automatic grow(input logic [NODE_W-1:0] v, input logic [NODE_W-1:0] p);
    load(v, p);
    tree = {tree, v};
    last_node = v;
  endtask

  function automatic logic [NODE_W-1:0] any_known();
    return known[$urandom_range(known.size() - 1)];
  endfunction

  function automatic logic [NODE_W-1:0] query_node();
    if ($urandom_range(9) == 0) return any_known();
    return tree[$urandom_range(tree.size() - 1)];
  endfunction

  task automatic random_word();
    int                r;
    logic [NODE_W-1:0] v, p;
    r = $urandom_range(99);
    if (r < 2) begin
      v = NODE_W'($urandom);
      new_root(v);
    end else if (r < 47) begin
      // extend the chain half the time to build depth
      v = NODE_W'($urandom);
      p = ($urandom_range(1) == 1) ? last_node : tree[$urandom_range(tree.size() - 1)];
      grow(v, p);
    end else if (r < 51) begin
      // reload out of order: stale tables below, still defined
      load(any_known(), any_known());
    end else begin
      send_word(OP_QUERY, query_node(), query_node());
    end
  endtask

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst      <= 1'b1;
    start    <= 1'b0;
    request  <= '0;
    idle_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    new_root(16'h0000);
    grow(16'hFFFF, 16'h0000);
    grow(16'h5555, 16'hFFFF);
    grow(16'hAAAA, 16'h5555);
    grow(16'h1234, 16'h0000);
    grow(16'h00FF, 16'h1234);
    send_word(OP_QUERY, 16'h0000, 16'h0000);
    send_word(OP_QUERY, 16'hFFFF, 16'h0000);
    send_word(OP_QUERY, 16'h0000, 16'hFFFF);
    send_word(OP_QUERY, 16'hAAAA, 16'h00FF);
    send_word(OP_QUERY, 16'h00FF, 16'hAAAA);
    send_word(OP_QUERY, 16'h5555, 16'hAAAA);
    // second tree, then a query across the forest
    new_root(16'h8000);
    grow(16'h7FFF, 16'h8000);
    send_word(OP_QUERY, 16'h7FFF, 16'hAAAA);
    // hang an old root under a leaf: children keep stale entries
    load(16'h8000, 16'hAAAA);
    send_word(OP_QUERY, 16'h7FFF, 16'h1234);
    send_word(OP_QUERY, 16'h8000, 16'h5555);
    load(16'h5555, 16'h5555);
    send_word(OP_QUERY, 16'hAAAA, 16'h00FF);
    send_word(OP_QUERY, 16'h8000, 16'h0000);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_by_phase[ph];
      repeat (PHASE_WORDS) random_word();
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (3 * LIFT_LEVELS + 20) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
